// ----- design/rfct_pkg.sv -----
// Package for the response framer: request and result codes, field widths
// and the result record shared by the interfaces and the framer.
// No dependencies.
`default_nettype none

package rfct_pkg;

  localparam int unsigned TypeW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned RetryW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0] DefaultCharTicks = 16'd30;
  localparam logic [CountW-1:0] ResetFirstTicks  = 16'd1000;
  localparam logic [CountW-1:0] ResetCapacity    = 16'd100;
  localparam logic [RetryW-1:0] ResetRetryLimit  = 8'd0;

  typedef enum logic [TypeW-1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_e;

  typedef enum logic [TypeW-1:0] {
    KIND_BYTE   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    END_COMPLETE = 2'd0,
    END_OVERFLOW = 2'd1,
    END_NO_RESP  = 2'd2
  } end_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_TIMEOUT = 2'd0,
    CFG_CHAR_TIMEOUT  = 2'd1,
    CFG_RETRY_LIMIT   = 2'd2,
    CFG_CAPACITY      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TypeW-1:0]  kind;
    logic [ByteW-1:0]  data_byte;
    logic [CountW-1:0] byte_index;
    logic [1:0]        end_status;
    logic [CountW-1:0] frame_length;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/rfct_if.sv -----
// Handshake channels of the response framer: the request channel and the
// result channel. Depends on rfct_pkg for field widths.
`default_nettype none

interface rfct_req_if;
  logic                        valid;
  logic                        ready;
  logic [rfct_pkg::TypeW-1:0]  req_type;
  logic [rfct_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface rfct_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rfct_pkg::TypeW-1:0]  kind;
  logic [rfct_pkg::ByteW-1:0]  data_byte;
  logic [rfct_pkg::CountW-1:0] byte_index;
  logic [1:0]                  end_status;
  logic [rfct_pkg::CountW-1:0] frame_length;
  logic                        last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output end_status, output frame_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input end_status, input frame_length, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- design/response_framer_with_char_timeout.sv -----
// Response framer with inter-character timeout: frame state, timers and a
// three-entry result queue. Depends on rfct_pkg and the channels in rfct_if.
`default_nettype none

//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  req_i    | in  | valid/ready   | req_type, rx_byte
//  rsp_o    | out | valid/ready   | kind, data_byte, byte_index, end_status,
//           |     |               | frame_length, last
//  cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i (no read-back)
//
// Each request is handled in the cycle it is accepted: the frame state is
// updated at that edge and its zero, one or two results enter the queue,
// whose entry 0 drives the output. One request per cycle is taken while
// the queue holds at most one result, or two with one leaving; the depth
// of three sets how long requests keep flowing against a stalled channel.
// Reset clears the frame state and queue and loads the register defaults.

module response_framer_with_char_timeout (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rfct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rfct_pkg::CfgDataW-1:0] cfg_data_i,
  rfct_req_if.sink                           req_i,
  rfct_rsp_if.source                         rsp_o
);

  import rfct_pkg::*;

  localparam int unsigned QDepth = 3;

  // Configuration registers.
  logic [CountW-1:0] first_ticks_q;
  logic [CountW-1:0] char_ticks_q;
  logic [RetryW-1:0] retry_limit_q;
  logic [CountW-1:0] capacity_q;

  // Frame state.
  logic              active_q, active_d;
  logic              started_q, started_d;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [CountW-1:0] elapsed_q, elapsed_d;
  logic [RetryW-1:0] retries_q, retries_d;

  // Result queue; entry 0 drives the result channel.
  result_t     queue_q [QDepth];
  result_t     queue_d [QDepth];
  logic [1:0]  count_q, count_d;

  logic        accept;
  logic        pop;
  logic [1:0]  base;
  logic [1:0]  n_push;
  result_t     res0, res1;
  req_type_e   req_type;

  // An item may be taken whenever, after this cycle's pop, the queue still has
  // room for the two results that a single request can cause.
  assign pop     = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (count_q <= 2'd1) || ((count_q == 2'd2) && rsp_o.ready);
  assign accept  = req_i.valid && req_i.ready;
  assign base    = count_q - {1'b0, pop};
  assign req_type = req_type_e'(req_i.req_type);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_ticks_q <= ResetFirstTicks;
      char_ticks_q  <= DefaultCharTicks;
      retry_limit_q <= ResetRetryLimit;
      capacity_q    <= ResetCapacity;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_TIMEOUT: first_ticks_q <= cfg_data_i;
        CFG_CHAR_TIMEOUT:  char_ticks_q  <= cfg_data_i;
        CFG_RETRY_LIMIT:   retry_limit_q <= cfg_data_i[RetryW-1:0];
        CFG_CAPACITY:      capacity_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request decode: next frame state and the results caused by the request.
  always_comb begin
    logic [CountW-1:0] next_count;
    logic [CountW-1:0] inc_ticks;
    logic [CountW-1:0] limit;
    logic              full_after_byte;

    active_d     = active_q;
    started_d    = started_q;
    byte_count_d = byte_count_q;
    elapsed_d    = elapsed_q;
    retries_d    = retries_q;
    res0         = '0;
    res1         = '0;
    n_push       = 2'd0;

    next_count      = byte_count_q + 16'd1;
    // The frame is full once the new byte count + 1 reaches capacity; capacity 0 is full.
    full_after_byte = ({1'b0, next_count} + 17'd1) >= {1'b0, capacity_q};
    inc_ticks       = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;
    if (started_q) begin
      limit = (char_ticks_q == '0) ? DefaultCharTicks : char_ticks_q;
    end else begin
      limit = first_ticks_q;
    end

    if (accept) begin
      case (req_type)
        REQ_START: begin
          // A start opens a fresh frame, dropping any frame in flight; capacity 0 or 1 ends it at once.
          active_d     = 1'b1;
          started_d    = 1'b0;
          byte_count_d = '0;
          elapsed_d    = '0;
          retries_d    = retry_limit_q;
          if (capacity_q <= 16'd1) begin
            active_d        = 1'b0;
            res0.kind       = KIND_DONE;
            res0.end_status = END_OVERFLOW;
            res0.last       = 1'b1;
            n_push          = 2'd1;
          end
        end
        REQ_BYTE: begin
          if (active_q) begin
            byte_count_d    = next_count;
            started_d       = 1'b1;
            elapsed_d       = '0;
            res0.kind       = KIND_BYTE;
            res0.data_byte  = req_i.rx_byte;
            res0.byte_index = byte_count_q;
            if (full_after_byte) begin
              // The filling byte is followed by an overflow finish.
              active_d          = 1'b0;
              res1.kind         = KIND_DONE;
              res1.end_status   = END_OVERFLOW;
              res1.frame_length = next_count;
              res1.last         = 1'b1;
              n_push            = 2'd2;
            end else begin
              res0.last = 1'b1;
              n_push    = 2'd1;
            end
          end
        end
        REQ_TICK: begin
          if (active_q) begin
            elapsed_d = inc_ticks;
            if (inc_ticks >= limit) begin
              res0.last = 1'b1;
              n_push    = 2'd1;
              if (started_q) begin
                active_d          = 1'b0;
                res0.kind         = KIND_DONE;
                res0.end_status   = END_COMPLETE;
                res0.frame_length = byte_count_q;
              end else if (retries_q != '0) begin
                retries_d = retries_q - 8'd1;
                elapsed_d = '0;
                res0.kind = KIND_RESEND;
              end else begin
                active_d        = 1'b0;
                res0.kind       = KIND_DONE;
                res0.end_status = END_NO_RESP;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Queue update: shift out on pop, then append new results behind the rest.
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        queue_d[i] = queue_q[i+1];
      end else begin
        queue_d[i] = queue_q[i];
      end
      if ((n_push != 2'd0) && (2'(i) == base)) begin
        queue_d[i] = res0;
      end
      if ((n_push == 2'd2) && (2'(i) == base + 2'd1)) begin
        queue_d[i] = res1;
      end
    end
    count_d = base + n_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      started_q    <= 1'b0;
      byte_count_q <= '0;
      elapsed_q    <= '0;
      retries_q    <= '0;
      count_q      <= '0;
    end else begin
      active_q     <= active_d;
      started_q    <= started_d;
      byte_count_q <= byte_count_d;
      elapsed_q    <= elapsed_d;
      retries_q    <= retries_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  assign rsp_o.valid        = (count_q != 2'd0);
  assign rsp_o.kind         = queue_q[0].kind;
  assign rsp_o.data_byte    = queue_q[0].data_byte;
  assign rsp_o.byte_index   = queue_q[0].byte_index;
  assign rsp_o.end_status   = queue_q[0].end_status;
  assign rsp_o.frame_length = queue_q[0].frame_length;
  assign rsp_o.last         = queue_q[0].last;

  // A full queue must hold off new requests.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd3) |-> !req_i.ready)
    else $error("request taken while result queue is full");

  // A byte taken during an open frame always leaves a result to deliver.
  a_byte_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type == REQ_BYTE) && active_q) |=> (count_q != 2'd0))
    else $error("accepted byte produced no result");

  // A finish result always closes the frame.
  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (n_push != 2'd0) &&
     ((res0.kind == KIND_DONE) || (res1.kind == KIND_DONE && n_push == 2'd2)))
    |=> !active_q)
    else $error("frame still open after finish result");

  // A resend consumes exactly one retry.
  a_resend_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (n_push == 2'd1) && (res0.kind == KIND_RESEND))
    |=> (retries_q == $past(retries_q) - 8'd1))
    else $error("resend did not consume a retry");

  // A finish result at the output is always the last one of its request.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.kind == KIND_DONE)) |-> rsp_o.last)
    else $error("finish result not marked last");

endmodule

`default_nettype wire

// ----- verif/tb_response_framer_with_char_timeout.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the response framer with inter-character timeout.
// Drives start, byte and tick requests and checks every result against a frame
// predictor. Depends on rfct_pkg, the channels in rfct_if and the framer RTL.

module tb_response_framer_with_char_timeout;
  import rfct_pkg::*;

  // Request code 3 is not part of the request enum. The framer must ignore it.
  localparam logic [TypeW-1:0] ReqUnused = 2'd3;
  // Cycles without any accepted request or result before the run is declared hung.
  localparam int StallLimit = 4000;
  // Margins for the last result to clear the framer's queue. These margins are generous.
  localparam int SettleCycles = 4;
  localparam int TailCycles = 10;

  // Tracks the open frame the way the framer should, and holds the results
  // that the framer still owes, oldest first.
  class frame_tracker;
    logic [CountW-1:0] first_ticks;
    logic [CountW-1:0] char_ticks;
    logic [RetryW-1:0] retry_max;
    logic [CountW-1:0] capacity;
    bit                active;
    bit                started;
    logic [CountW-1:0] byte_count;
    logic [CountW-1:0] elapsed;
    logic [RetryW-1:0] retries_left;
    result_t           pending_results[$];
    int                errors;

    function new();
      first_ticks  = ResetFirstTicks;
      char_ticks   = DefaultCharTicks;
      retry_max    = ResetRetryLimit;
      capacity     = ResetCapacity;
      active       = 1'b0;
      started      = 1'b0;
      byte_count   = '0;
      elapsed      = '0;
      retries_left = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_FIRST_TIMEOUT: first_ticks = value;
        CFG_CHAR_TIMEOUT:  char_ticks = value;
        CFG_RETRY_LIMIT:   retry_max = value[RetryW-1:0];
        CFG_CAPACITY:      capacity = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // A capacity of zero acts like a capacity of one: no byte fits.
    function bit frame_full();
      logic [CountW-1:0] max_bytes;
      max_bytes = (capacity == '0) ? '0 : capacity - 1'b1;
      return byte_count >= max_bytes;
    endfunction

    function logic [CountW-1:0] tick_limit();
      if (!started) return first_ticks;
      return (char_ticks == '0) ? DefaultCharTicks : char_ticks;
    endfunction

    // Ticks until the next timeout fires.
    function int ticks_to_timeout();
      return int'(tick_limit()) - int'(elapsed);
    endfunction

    // Rough number of ticks until silence alone closes the frame.
    function int ticks_to_close();
      int lim;
      lim = int'(tick_limit());
      if (!active) return 0;
      if (started) return lim - int'(elapsed);
      return (int'(retries_left) + 1) * ((lim == 0) ? 1 : lim) - int'(elapsed);
    endfunction

    function void add_result(kind_e kind, logic [ByteW-1:0] data, logic [CountW-1:0] idx,
                             end_status_e status, logic [CountW-1:0] length, logic last);
      result_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.byte_index   = idx;
      r.end_status   = status;
      r.frame_length = length;
      r.last         = last;
      pending_results.push_back(r);
    endfunction

    // Advances the frame by one accepted request and queues what it produces.
    function void accept_request(logic [TypeW-1:0] req, logic [ByteW-1:0] rx);
      logic [CountW-1:0] idx;
      if (req == REQ_START) begin
        // A start opens a fresh frame, an open one dropped silently; capacity 0 or 1 ends it at once.
        active       = 1'b1;
        started      = 1'b0;
        byte_count   = '0;
        elapsed      = '0;
        retries_left = retry_max;
        if (frame_full()) begin
          active = 1'b0;
          add_result(KIND_DONE, '0, '0, END_OVERFLOW, '0, 1'b1);
        end
      end else if (active && req == REQ_BYTE) begin
        idx        = byte_count;
        byte_count = byte_count + 1'b1;
        started    = 1'b1;
        elapsed    = '0;
        if (frame_full()) begin
          active = 1'b0;
          add_result(KIND_BYTE, rx, idx, END_COMPLETE, '0, 1'b0);
          add_result(KIND_DONE, '0, '0, END_OVERFLOW, byte_count, 1'b1);
        end else begin
          add_result(KIND_BYTE, rx, idx, END_COMPLETE, '0, 1'b1);
        end
      end else if (active && req == REQ_TICK) begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (elapsed >= tick_limit()) begin
          if (started) begin
            active = 1'b0;
            add_result(KIND_DONE, '0, '0, END_COMPLETE, byte_count, 1'b1);
          end else if (retries_left != '0) begin
            retries_left = retries_left - 1'b1;
            elapsed      = '0;
            add_result(KIND_RESEND, '0, '0, END_COMPLETE, '0, 1'b1);
          end else begin
            active = 1'b0;
            add_result(KIND_DONE, '0, '0, END_NO_RESP, '0, 1'b1);
          end
        end
      end
      // Bytes and ticks while idle, and the unused request code, do nothing.
    endfunction

    function void compare_field(string name, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("kind: expected no result, actual %0d", got.kind);
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("end_status", want.end_status, got.end_status);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rfct_req_if req_if();
  rfct_rsp_if rsp_if();

  frame_tracker tracker = new();

  // When cleared, neither side inserts idle cycles or stalls.
  bit gaps_on = 1'b1;
  int items_sent;
  int quiet_cycles = 0;

  response_framer_with_char_timeout dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // The result consumer stalls at random, except during the no-gap stretch.
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      rsp_if.ready = 1'b1;
    end else begin
      rsp_if.ready = ($urandom_range(0, 99) >= 28);
    end
  end

  // Both channels are sampled at the rising edge, before the framer's own
  // updates land, so a request and a result taken at the same edge never
  // interfere: the result always belongs to an older request.
  always @(posedge clk_i) begin
    result_t got;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        tracker.accept_request(req_if.req_type, req_if.rx_byte);
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.kind         = rsp_if.kind;
        got.data_byte    = rsp_if.data_byte;
        got.byte_index   = rsp_if.byte_index;
        got.end_status   = rsp_if.end_status;
        got.frame_length = rsp_if.frame_length;
        got.last         = rsp_if.last;
        tracker.check_result(got);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one request. Called at a falling edge and returns at a falling edge.
  // Idle cycles carry random payload with valid low.
  task automatic put_request(input logic [TypeW-1:0] req, input logic [ByteW-1:0] rx);
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      req_if.valid    = 1'b0;
      req_if.req_type = TypeW'($urandom_range(0, 3));
      req_if.rx_byte  = ByteW'($urandom);
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = req;
    req_if.rx_byte  = rx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Holds off new requests until the framer owes nothing.
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Registers may only change while the framer is idle, so drain first and
  // then wait a SettleCycles margin before the register writes.
  task automatic quiesce();
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic [CountW-1:0] first, input logic [CountW-1:0] inter,
                           input logic [RetryW-1:0] retries, input logic [CountW-1:0] cap);
    quiesce();
    write_reg(CFG_FIRST_TIMEOUT, first);
    write_reg(CFG_CHAR_TIMEOUT, inter);
    write_reg(CFG_RETRY_LIMIT, CfgDataW'(retries));
    write_reg(CFG_CAPACITY, cap);
  endtask

  // One well-formed frame with random content: a start, then bytes separated
  // by runs of ticks that mostly stay under the current limit and now and
  // then reach it, which forces a resend or an early finish. A little noise
  // (any request code, including a start in mid-frame) is mixed in.
  task automatic run_frame();
    int want_bytes;
    int room;
    int gap;
    int guard;
    put_request(REQ_START, ByteW'($urandom));
    room = (tracker.capacity > 16'd22) ? 24 : int'(tracker.capacity) + 2;
    want_bytes = $urandom_range(0, room);
    for (int n = 0; n < want_bytes && tracker.active; n++) begin
      room = tracker.ticks_to_timeout();
      if (room <= 64 && $urandom_range(0, 9) == 0) begin
        gap = (room < 1) ? 1 : room;
      end else if (room > 1) begin
        gap = $urandom_range(0, (room > 6) ? 5 : room - 1);
      end else begin
        gap = 0;
      end
      repeat (gap) begin
        if (tracker.active) put_request(REQ_TICK, ByteW'($urandom));
      end
      if ($urandom_range(0, 19) == 0) begin
        put_request(TypeW'($urandom_range(0, 3)), ByteW'($urandom));
      end
      if (tracker.active) put_request(REQ_BYTE, ByteW'($urandom));
    end
    // Let silence finish the frame when that is cheap; with long limits the
    // next start simply drops it instead.
    if (tracker.ticks_to_close() <= 300) begin
      guard = 0;
      while (tracker.active && guard < 400) begin
        put_request(REQ_TICK, ByteW'($urandom));
        guard++;
      end
    end
    // Requests that arrive while idle must be swallowed.
    if (!tracker.active && $urandom_range(0, 3) == 0) begin
      put_request(TypeW'($urandom_range(1, 3)), ByteW'($urandom));
    end
  endtask

  // One register setting and a budget of requests. Partway in, the sender
  // waits until every owed result has come back.
  task automatic run_phase(input logic [CountW-1:0] first, input logic [CountW-1:0] inter,
                           input logic [RetryW-1:0] retries, input logic [CountW-1:0] cap,
                           input int budget);
    int stop_at;
    int frames;
    configure(first, inter, retries, cap);
    stop_at = items_sent + budget;
    frames = 0;
    while (items_sent < stop_at) begin
      run_frame();
      frames++;
      if (frames == 3) wait_drained();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_FIRST_TIMEOUT;
    cfg_data_i      = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_START;
    req_if.rx_byte  = '0;
    rsp_if.ready    = 1'b0;
    items_sent      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, first with the register values from reset.
    // While idle, bytes, ticks and the unused code produce nothing.
    put_request(REQ_BYTE, 8'h3C);
    put_request(REQ_TICK, 8'h00);
    put_request(ReqUnused, 8'hFF);
    // Extreme byte values, then a start in mid-frame that drops the frame
    // and restarts the index at zero. The unused code is ignored in a frame.
    put_request(REQ_START, 8'h00);
    put_request(REQ_BYTE, 8'h00);
    put_request(REQ_BYTE, 8'hFF);
    put_request(REQ_TICK, 8'h00);
    put_request(ReqUnused, 8'h00);
    put_request(REQ_START, 8'hFF);
    put_request(REQ_BYTE, 8'h5A);

    // A zero first timeout fires on the first tick: two resends, then the
    // frame ends with no response.
    configure(16'd0, 16'd0, 8'd2, 16'd3);
    put_request(REQ_START, 8'h00);
    put_request(REQ_TICK, 8'h00);
    put_request(REQ_TICK, 8'h00);
    put_request(REQ_TICK, 8'h00);
    // Capacity three: the second byte fills the frame and ends it as overflow.
    put_request(REQ_START, 8'h00);
    put_request(REQ_BYTE, 8'h81);
    put_request(REQ_BYTE, 8'h7E);
    // Capacities of one and zero overflow right at the start.
    quiesce();
    write_reg(CFG_CAPACITY, 16'd1);
    put_request(REQ_START, 8'h00);
    quiesce();
    write_reg(CFG_CAPACITY, 16'd0);
    put_request(REQ_START, 8'h00);

    // Random part: a range of settings including the register extremes.
    run_phase(16'd3, 16'd4, 8'd2, 16'd8, 260);
    // A stretch with no idling on either side; a zero inter-character limit
    // means the default of 30 ticks.
    gaps_on = 1'b0;
    run_phase(16'd0, 16'd0, 8'd0, 16'd5, 260);
    gaps_on = 1'b1;
    run_phase(16'd2, 16'd1, 8'd255, 16'd12, 260);
    run_phase(16'd65535, 16'd65535, 8'd1, 16'd65535, 80);
    run_phase(16'd5, 16'd3, 8'd3, 16'd2, 220);
    run_phase(16'd1, 16'd2, 8'd0, 16'd1, 120);
    for (int p = 0; p < 3; p++) begin
      run_phase(CountW'($urandom_range(0, 8)), CountW'($urandom_range(0, 6)),
                RetryW'($urandom_range(0, 4)), CountW'($urandom_range(1, 20)), 250);
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rfct_pkg.sv
design/rfct_if.sv
design/response_framer_with_char_timeout.sv
verif/tb_response_framer_with_char_timeout.sv
